// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands shared by the RTL. Define ASSERT_OFF to
// compile them away.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Implication checked in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Implication checked in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== hdl/rpip_pkg.sv =====
// ---------------------------------------------------------------------------
// rpip_pkg
// Widths and character codes of the radix-prefixed integer parser.
// ---------------------------------------------------------------------------
package rpip_pkg;

   // Width of the internal accumulator; results wrap at this width.
   localparam int VALUE_WIDTH = 64;
   // Width of the result word on the port.
   localparam int OUT_WIDTH   = 64;
   localparam int CHAR_WIDTH  = 8;

   localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_WIDTH-1:0] CH_UA    = 8'h41;
   localparam logic [CHAR_WIDTH-1:0] CH_UZ    = 8'h5A;
   localparam logic [CHAR_WIDTH-1:0] CH_LA    = 8'h61;
   localparam logic [CHAR_WIDTH-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_WIDTH-1:0] CH_PLUS  = 8'h2B;

   localparam logic [CHAR_WIDTH-1:0] DEC_RADIX = 8'd10;

endpackage

// ===== hdl/radix_prefixed_integer_parser_core.sv =====
// ---------------------------------------------------------------------------
// radix_prefixed_integer_parser_core
// Converts a stream of ASCII characters of one number token into its
// signed integer value, with an optional sign and radix prefix.
// ---------------------------------------------------------------------------
// Usage:
// The req channel carries one character of a token per word, together with
// an end-of-token flag on the token's last character. An optional '-' or '+'
// may lead. A body starting with '0' followed by a byte at or above 'a'
// selects radix (letter + 1 - 'a'), and the digits that follow are 0-9 and
// A-Z, where any other byte counts as -1. Otherwise the body is decimal.
// A space after the first body character freezes the value, except just after a radix letter.
// The rsp channel carries exactly one word per token: the value, wrapped to
// VALUE_WIDTH bits and sign-extended to 64 bits. A token that ends right
// after its sign or right after its radix letter gives zero.
// The last character goes from the input register to the result register,
// which drives rsp_valid. Throughput is one character per cycle, but for an
// end-of-token word held back by a stalled result; each character costs one
// 64 x 8 multiply-add from the accumulator register back into itself.
// While rsp_valid is held by a stalled receiver, characters that do not end
// a token still flow; an end-of-token word waits in the input register, and
// only then does req_ready drop. Synchronous reset empties both registers
// and returns the parser to the start of a token.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module radix_prefixed_integer_parser_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [rpip_pkg::CHAR_WIDTH-1:0]     req_character,
   input  logic                                req_end_of_token,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [rpip_pkg::OUT_WIDTH-1:0] rsp_value
);
   import rpip_pkg::*;

   // Parse phases. The sign may only be the first byte; after the first
   // body character the phase says how later bytes are interpreted.
   typedef enum logic [2:0] {
      PH_START,
      PH_SIGNED,
      PH_ZERO,
      PH_RADIX,
      PH_DEC,
      PH_BASE,
      PH_STOPPED
   } phase_type;

   // Signed per-digit contribution; wide enough for -(255 - '0').
   localparam int TERM_WIDTH = 10;

   // Input register.
   logic                    stg_valid_ff, stg_valid_in;
   logic [CHAR_WIDTH-1:0]   stg_char_ff;
   logic                    stg_eot_ff;

   // Parser state.
   phase_type               phase_ff, phase_in;
   logic                    negative_ff, negative_in;
   logic [CHAR_WIDTH-1:0]   radix_ff, radix_in;
   logic [VALUE_WIDTH-1:0]  acc_ff, acc_in;

   // Result register.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_WIDTH-1:0] rsp_value_ff, rsp_value_in;

   logic                    advance;
   logic                    req_fire;
   logic signed [TERM_WIDTH-1:0] dec_term;
   logic signed [TERM_WIDTH-1:0] digit_term;
   logic signed [TERM_WIDTH-1:0] mac_term;
   logic signed [TERM_WIDTH-1:0] signed_term;
   logic [CHAR_WIDTH-1:0]   mac_factor;
   logic [VALUE_WIDTH-1:0]  mac_sum;
   logic signed [VALUE_WIDTH-1:0] acc_signed;
   logic                    is_space;
   logic                    has_value;

   // Handshake. Characters that do not end a token never need the result
   // register, so only an end-of-token word waits for it.
   assign advance   = stg_valid_ff && (!stg_eot_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !stg_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      if (req_fire) begin
         stg_valid_in = 1'b1;
      end else if (advance) begin
         stg_valid_in = 1'b0;
      end else begin
         stg_valid_in = stg_valid_ff;
      end
   end

   // Digit terms. Decimal bytes add (byte - '0') even when out of range;
   // radix digits are 0..35 or -1 for any other byte.
   assign dec_term = $signed({2'b00, stg_char_ff}) - TERM_WIDTH'(signed'(CH_ZERO));

   always_comb begin
      if (stg_char_ff >= CH_ZERO && stg_char_ff <= CH_NINE) begin
         digit_term = $signed(TERM_WIDTH'(stg_char_ff - CH_ZERO));
      end else if (stg_char_ff >= CH_UA && stg_char_ff <= CH_UZ) begin
         digit_term = $signed(TERM_WIDTH'(stg_char_ff - CH_UA) + TERM_WIDTH'(DEC_RADIX));
      end else begin
         digit_term = '1;
      end
   end

   // The accumulator carries the value already negated for a '-' token, so
   // the final result needs no extra negation: -(a*r + d) = (-a)*r - d.
   assign mac_term    = (phase_ff == PH_BASE) ? digit_term : dec_term;
   assign signed_term = negative_ff ? -mac_term : mac_term;
   assign mac_factor  = (phase_ff == PH_BASE) ? radix_ff : DEC_RADIX;
   assign mac_sum     = acc_ff * VALUE_WIDTH'(mac_factor) + VALUE_WIDTH'(signed_term);
   assign is_space    = (stg_char_ff == CH_SPACE);

   always_comb begin
      phase_in    = phase_ff;
      negative_in = negative_ff;
      radix_in    = radix_ff;
      acc_in      = acc_ff;
      unique case (phase_ff)
         PH_START: begin
            if (stg_char_ff == CH_MINUS || stg_char_ff == CH_PLUS) begin
               negative_in = (stg_char_ff == CH_MINUS);
               phase_in    = PH_SIGNED;
            end else begin
               acc_in   = VALUE_WIDTH'(dec_term);
               phase_in = (stg_char_ff == CH_ZERO) ? PH_ZERO : PH_DEC;
            end
         end
         PH_SIGNED: begin
            acc_in   = VALUE_WIDTH'(negative_ff ? -dec_term : dec_term);
            phase_in = (stg_char_ff == CH_ZERO) ? PH_ZERO : PH_DEC;
         end
         PH_ZERO: begin
            if (stg_char_ff >= CH_LA) begin
               radix_in = stg_char_ff + CHAR_WIDTH'(1) - CH_LA;
               phase_in = PH_RADIX;
            end else if (is_space) begin
               phase_in = PH_STOPPED;
            end else begin
               acc_in   = mac_sum;
               phase_in = PH_DEC;
            end
         end
         PH_RADIX: begin
            acc_in   = VALUE_WIDTH'(negative_ff ? -digit_term : digit_term);
            phase_in = PH_BASE;
         end
         PH_DEC, PH_BASE: begin
            if (is_space) begin
               phase_in = PH_STOPPED;
            end else begin
               acc_in = mac_sum;
            end
         end
         default: begin
            phase_in = PH_STOPPED;
         end
      endcase
   end

   // A token that ends after only a sign or only a radix prefix yields zero.
   assign has_value  = (phase_in != PH_SIGNED) && (phase_in != PH_RADIX);
   assign acc_signed = $signed(acc_in);
   assign rsp_value_in = has_value ? OUT_WIDTH'(acc_signed) : '0;

   always_comb begin
      if (advance && stg_eot_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_START;
         negative_ff  <= 1'b0;
         radix_ff     <= DEC_RADIX;
      end else begin
         stg_valid_ff <= stg_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            if (stg_eot_ff) begin
               // Token done: next token starts from a clean state.
               phase_ff    <= PH_START;
               negative_ff <= 1'b0;
               radix_ff    <= DEC_RADIX;
            end else begin
               phase_ff    <= phase_in;
               negative_ff <= negative_in;
               radix_ff    <= radix_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         stg_char_ff <= req_character;
         stg_eot_ff  <= req_end_of_token;
      end
      if (advance) begin
         acc_ff <= acc_in;
      end
      if (advance && stg_eot_ff) begin
         rsp_value_ff <= rsp_value_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

   // A finished token always leaves the parser at the start of a new one.
   `ASSERT_NEXT(a_token_restart, clock, reset, advance && stg_eot_ff,
      phase_ff == PH_START && !negative_ff && radix_ff == DEC_RADIX)

   // A held result is never overwritten by the waiting end-of-token word.
   `ASSERT_NEXT(a_result_held, clock, reset,
      stg_valid_ff && stg_eot_ff && rsp_valid_ff && !rsp_ready,
      stg_valid_ff && $stable(rsp_value_ff))

   // Outside radix mode and the stopped phase, the radix register sits at ten.
   `ASSERT_IMPLIES(a_radix_idle, clock, reset,
      phase_ff == PH_START || phase_ff == PH_SIGNED || phase_ff == PH_ZERO ||
      phase_ff == PH_DEC,
      radix_ff == DEC_RADIX)

endmodule
